// ----- hw/rtl/awb_pkg.sv -----
// Package: widths, constants and the transaction types of the gain balance block.
package awb_pkg;
    localparam int RatioW   = 16;
    localparam int GainW    = 16;
    localparam int CfgIdxW  = 1;
    localparam int DivNumW  = 25;   // 512 * 16-bit typical ratio
    localparam int QW       = 25;   // scaled ratio width
    localparam int PDepth   = 32;   // queue depth default
    localparam logic [GainW-1:0] UnityGain = 16'h0100;
    localparam logic [QW-1:0]    RatioScale = 25'd512;

    localparam logic [CfgIdxW-1:0] RegRgTyp = 1'b0;
    localparam logic [CfgIdxW-1:0] RegBgTyp = 1'b1;

    typedef enum logic [1:0] {
        t_CASE_BOTH = 2'd0,
        t_CASE_BLUE = 2'd1,
        t_CASE_RED  = 2'd2,
        t_CASE_ERR  = 2'd3
    } t_case;

    // Front -> back transaction: both scaled ratios and the chosen case.
    typedef struct packed {
        logic [QW-1:0] rs;
        logic [QW-1:0] bs;
        t_case         sel;
    } t_job;
endpackage

// ----- hw/rtl/awb_div.sv -----
// Module: pipelined restoring divider, one quotient bit per stage.
module awb_div #(
    parameter int NW = 32,
    parameter int DW = 25,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [NW:0]   r_vld;
    logic [NW-1:0] r_q   [NW+1];
    logic [DW-1:0] r_rem [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [TW-1:0] r_tag [NW+1];

    always_comb begin
        r_vld[0] = i_vld;
        r_q[0]   = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_tag[0] = i_tag;
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW:0]   w_tr;
        logic          w_ge;
        always_comb begin
            w_tr = {r_rem[s], r_q[s][NW-1]};
            w_ge = w_tr >= {1'b0, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rem[s+1] <= w_ge ? DW'(w_tr - {1'b0, r_den[s]}) : w_tr[DW-1:0];
                r_q[s+1]   <= {r_q[s][NW-2:0], w_ge};
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_vld = r_vld[NW];
    assign o_quo = r_q[NW];
    assign o_tag = r_tag[NW];
endmodule

// ----- hw/rtl/awb_front.sv -----
// Module: front end, forms the scaled ratios and classifies the case.
module awb_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [awb_pkg::RatioW-1:0] i_rg_typ,
    input  logic [awb_pkg::RatioW-1:0] i_bg_typ,
    input  logic [awb_pkg::RatioW-1:0] i_measured_rg,
    input  logic [awb_pkg::RatioW-1:0] i_measured_bg,
    output logic                      o_vld,
    output awb_pkg::t_job             o_job
);
    localparam int NW = awb_pkg::DivNumW;
    localparam int QW = awb_pkg::QW;

    logic          w_zero;
    logic          w_rs_vld, w_bs_vld;
    logic [NW-1:0] w_rs, w_bs;
    logic          w_err;
    logic          unused_bv;
    awb_pkg::t_job r_job, n_job;
    logic          r_vld;

    assign w_zero = (i_measured_rg == '0) || (i_measured_bg == '0);

    awb_div #(.NW(NW), .DW(awb_pkg::RatioW), .TW(1)) u_rs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(i_vld),
        .i_num({i_rg_typ, 9'd0}), .i_den(i_measured_rg), .i_tag(w_zero),
        .o_vld(w_rs_vld), .o_quo(w_rs), .o_tag(w_err)
    );
    awb_div #(.NW(NW), .DW(awb_pkg::RatioW), .TW(1)) u_bs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(i_vld),
        .i_num({i_bg_typ, 9'd0}), .i_den(i_measured_bg), .i_tag(1'b0),
        .o_vld(w_bs_vld), .o_quo(w_bs), .o_tag(unused_bv)
    );

    always_comb begin
        n_job.rs = QW'(w_rs);
        n_job.bs = QW'(w_bs);
        if (w_err || unused_bv || !w_bs_vld) begin
            n_job.sel = awb_pkg::t_CASE_ERR;
        end else if (n_job.rs >= awb_pkg::RatioScale && n_job.bs >= awb_pkg::RatioScale) begin
            n_job.sel = awb_pkg::t_CASE_BOTH;
        end else if (n_job.rs >= n_job.bs) begin
            n_job.sel = (n_job.bs == '0) ? awb_pkg::t_CASE_ERR : awb_pkg::t_CASE_BLUE;
        end else begin
            n_job.sel = (n_job.rs == '0) ? awb_pkg::t_CASE_ERR : awb_pkg::t_CASE_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= w_rs_vld;
        end
        if (i_en) begin
            r_job <= n_job;
        end
    end

    assign o_vld = r_vld;
    assign o_job = r_job;
endmodule

// ----- hw/rtl/awb_fifo.sv -----
// Module: transaction queue between front and back.
module awb_fifo #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [$clog2(D):0] o_cnt,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(D);
    logic [W-1:0]  r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(D-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(D-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_empty = (r_cnt == '0);
    assign o_cnt   = r_cnt;
    assign o_data  = r_mem[r_rp];
endmodule

// ----- hw/rtl/awb_back.sv -----
// Module: back end, final gain divisions and output register.
module awb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  awb_pkg::t_job             i_job,
    output logic                      o_rdy,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [awb_pkg::GainW-1:0] o_red_gain,
    output logic [awb_pkg::GainW-1:0] o_green_gain,
    output logic [awb_pkg::GainW-1:0] o_blue_gain,
    output logic                      o_divide_error
);
    localparam int QW = awb_pkg::QW;
    localparam int G  = awb_pkg::GainW;

    logic          w_en;
    logic          w_dv;
    logic [31:0]   w_num_a, w_q_a, w_q_b;
    logic [QW-1:0] w_den;
    logic [1:0]    w_tag, w_tag_b;
    logic          w_bv;
    logic          r_valid;
    logic [G-1:0]  r_red, r_green, r_blue;
    logic          r_err;

    // Pipeline advances unless a result is stuck at the output.
    assign w_en  = !r_valid || i_ready;
    assign o_rdy = w_en;

    // divider A: red (both/blue) or green (red case); divider B: green or blue
    always_comb begin
        unique case (i_job.sel)
            awb_pkg::t_CASE_BOTH: begin
                w_num_a = {i_job.rs[23:0], 8'd0};
                w_den   = awb_pkg::RatioScale;
            end
            awb_pkg::t_CASE_BLUE: begin
                w_num_a = {i_job.rs[23:0], 8'd0};
                w_den   = i_job.bs;
            end
            awb_pkg::t_CASE_RED: begin
                w_num_a = 32'h0002_0000;
                w_den   = i_job.rs;
            end
            default: begin
                w_num_a = '0;
                w_den   = QW'(1);
            end
        endcase
    end

    logic [31:0] w_num_b;
    logic [QW-1:0] w_den_b;
    always_comb begin
        unique case (i_job.sel)
            awb_pkg::t_CASE_BOTH: begin
                w_num_b = {i_job.bs[23:0], 8'd0};
                w_den_b = awb_pkg::RatioScale;
            end
            awb_pkg::t_CASE_BLUE: begin
                w_num_b = 32'h0002_0000;
                w_den_b = i_job.bs;
            end
            awb_pkg::t_CASE_RED: begin
                w_num_b = {i_job.bs[23:0], 8'd0};
                w_den_b = i_job.rs;
            end
            default: begin
                w_num_b = '0;
                w_den_b = QW'(1);
            end
        endcase
    end

    awb_div #(.NW(32), .DW(QW), .TW(2)) u_da (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_vld),
        .i_num(w_num_a), .i_den(w_den), .i_tag(i_job.sel),
        .o_vld(w_dv), .o_quo(w_q_a), .o_tag(w_tag)
    );
    awb_div #(.NW(32), .DW(QW), .TW(2)) u_db (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_vld),
        .i_num(w_num_b), .i_den(w_den_b), .i_tag(i_job.sel),
        .o_vld(w_bv), .o_quo(w_q_b), .o_tag(w_tag_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_dv && w_bv;
        end
        if (w_en) begin
            unique case (awb_pkg::t_case'(w_tag | w_tag_b))
                awb_pkg::t_CASE_BOTH: begin
                    r_red <= w_q_a[G-1:0]; r_green <= awb_pkg::UnityGain;
                    r_blue <= w_q_b[G-1:0]; r_err <= 1'b0;
                end
                awb_pkg::t_CASE_BLUE: begin
                    r_red <= w_q_a[G-1:0]; r_green <= w_q_b[G-1:0];
                    r_blue <= awb_pkg::UnityGain; r_err <= 1'b0;
                end
                awb_pkg::t_CASE_RED: begin
                    r_red <= awb_pkg::UnityGain; r_green <= w_q_a[G-1:0];
                    r_blue <= w_q_b[G-1:0]; r_err <= 1'b0;
                end
                default: begin
                    r_red <= awb_pkg::UnityGain; r_green <= awb_pkg::UnityGain;
                    r_blue <= awb_pkg::UnityGain; r_err <= 1'b1;
                end
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_red_gain     = r_red;
    assign o_green_gain   = r_green;
    assign o_blue_gain    = r_blue;
    assign o_divide_error = r_err;
endmodule

// ----- hw/rtl/awb_channel_gain_balance.sv -----
// Top level: white balance channel gain computation from measured ratios.
// Input channel i_valid/o_ready carries one measured_rg/measured_bg pair per
// transaction; output channel o_valid/i_ready carries red, green and blue gains
// and the divide error flag. Typical ratios are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must do so only while the block is idle.
// The block does not enforce this. Without stalls a transaction passes a
// 25-stage ratio divider pipeline and a classify register in the front, the
// queue, a 32-stage gain divider pipeline and an output register in the back.
// Throughput is one transaction per cycle while o_ready and i_ready stay high.
// The front runs freely; every transaction in flight in it is given a reserved
// slot in the queue, so o_ready drops only when the queue could fill.
// When the receiver stalls, the back pipeline and output register hold and
// the queue absorbs the front's transactions.
// Reset is synchronous: pipelines and queue empty, registers go to their
// default typical ratios of 582 and 567.
module awb_channel_gain_balance #(
    parameter int QDepth = awb_pkg::PDepth
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [awb_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [awb_pkg::RatioW-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [awb_pkg::RatioW-1:0]  i_measured_rg,
    input  logic [awb_pkg::RatioW-1:0]  i_measured_bg,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [awb_pkg::GainW-1:0]   o_red_gain,
    output logic [awb_pkg::GainW-1:0]   o_green_gain,
    output logic [awb_pkg::GainW-1:0]   o_blue_gain,
    output logic                       o_divide_error
);
    localparam int CW = $clog2(QDepth) + 1;

    logic [awb_pkg::RatioW-1:0] r_rg_typ, r_bg_typ;
    logic          w_acc, w_fv, w_empty, w_pop, w_brdy;
    awb_pkg::t_job w_fjob, w_qjob;
    logic [CW-1:0] w_cnt;
    logic [CW-1:0] r_fly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rg_typ <= 16'd582;
            r_bg_typ <= 16'd567;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                awb_pkg::RegRgTyp: r_rg_typ <= i_cfg_data;
                awb_pkg::RegBgTyp: r_bg_typ <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_acc   = i_valid && o_ready;
    assign o_ready = (32'(w_cnt) + 32'(r_fly)) < 32'(QDepth);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fly <= '0;
        end else begin
            r_fly <= r_fly + CW'(w_acc) - CW'(w_fv);
        end
    end

    awb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(1'b1), .i_vld(w_acc),
        .i_rg_typ(r_rg_typ), .i_bg_typ(r_bg_typ),
        .i_measured_rg(i_measured_rg), .i_measured_bg(i_measured_bg),
        .o_vld(w_fv), .o_job(w_fjob)
    );

    assign w_pop = !w_empty && w_brdy;

    awb_fifo #(.W($bits(awb_pkg::t_job)), .D(QDepth)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_fv), .i_data(w_fjob),
        .i_pop(w_pop), .o_empty(w_empty), .o_cnt(w_cnt), .o_data(w_qjob)
    );

    awb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(w_pop), .i_job(w_qjob),
        .o_rdy(w_brdy), .o_valid(o_valid), .i_ready(i_ready),
        .o_red_gain(o_red_gain), .o_green_gain(o_green_gain),
        .o_blue_gain(o_blue_gain), .o_divide_error(o_divide_error)
    );
endmodule

// ----- dv/tb.sv -----
// Testbench for the white balance channel gain block: random and directed ratios, scoreboard.
`timescale 1ns / 1ps

module tb;
    typedef struct packed {
        logic [awb_pkg::RatioW-1:0] rg;
        logic [awb_pkg::RatioW-1:0] bg;
    } t_ratio_pair;

    typedef struct packed {
        logic [awb_pkg::GainW-1:0] red;
        logic [awb_pkg::GainW-1:0] green;
        logic [awb_pkg::GainW-1:0] blue;
        logic                      err;
    } t_gains;

    localparam int DrainCycles = 80;
    localparam int LongHold    = 300;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [awb_pkg::CfgIdxW-1:0] i_cfg_idx;
    logic [awb_pkg::RatioW-1:0]  i_cfg_data;
    logic                        i_valid;
    logic                        o_ready;
    logic [awb_pkg::RatioW-1:0]  i_measured_rg;
    logic [awb_pkg::RatioW-1:0]  i_measured_bg;
    logic                        o_valid;
    logic                        i_ready;
    logic [awb_pkg::GainW-1:0]   o_red_gain;
    logic [awb_pkg::GainW-1:0]   o_green_gain;
    logic [awb_pkg::GainW-1:0]   o_blue_gain;
    logic                        o_divide_error;

    t_ratio_pair pending_pairs[$];
    t_gains      expected_gains[$];
    logic [awb_pkg::RatioW-1:0] rg_typ;
    logic [awb_pkg::RatioW-1:0] bg_typ;
    bit  quiet;
    bit  long_hold_req;
    bit  long_hold_done;
    int  send_idle;
    int  recv_hold;
    int  errors;

    awb_channel_gain_balance i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_gains balance_gains(t_ratio_pair p);
        t_gains g;
        bit [31:0] rs, bs, red, green, blue;
        bit err;
        red = 32'd256;
        green = 32'd256;
        blue = 32'd256;
        err = 1'b0;
        if (p.rg == 0 || p.bg == 0) begin
            err = 1'b1;
        end else begin
            rs = (32'd512 * 32'(rg_typ)) / 32'(p.rg);
            bs = (32'd512 * 32'(bg_typ)) / 32'(p.bg);
            if (rs >= 32'd512 && bs >= 32'd512) begin
                red  = (32'd256 * rs) / 32'd512;
                blue = (32'd256 * bs) / 32'd512;
            end else if (rs >= bs && bs < 32'd512) begin
                if (bs == 0) begin
                    err = 1'b1;
                end else begin
                    red   = (32'd256 * rs) / bs;
                    green = (32'd256 * 32'd512) / bs;
                end
            end else begin
                if (rs == 0) begin
                    err = 1'b1;
                end else begin
                    green = (32'd256 * 32'd512) / rs;
                    blue  = (32'd256 * bs) / rs;
                end
            end
        end
        if (err) begin
            red = 32'd256;
            green = 32'd256;
            blue = 32'd256;
        end
        g.red = red[15:0];
        g.green = green[15:0];
        g.blue = blue[15:0];
        g.err = err;
        return g;
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_idle <= 0;
        end else begin
            if (i_valid && o_ready)
                expected_gains.push_back(balance_gains({i_measured_rg, i_measured_bg}));
            if (!i_valid || o_ready) begin
                if (send_idle > 0) begin
                    i_valid <= 1'b0;
                    send_idle <= send_idle - 1;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    i_valid <= 1'b0;
                    send_idle <= $urandom_range(0, 4);
                end else if (pending_pairs.size() > 0) begin
                    t_ratio_pair p;
                    p = pending_pairs.pop_front();
                    i_measured_rg <= p.rg;
                    i_measured_bg <= p.bg;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_hold <= 0;
            long_hold_done <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_gains.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    t_gains e;
                    e = expected_gains.pop_front();
                    if (o_red_gain !== e.red) begin
                        $error("red_gain exp %0d got %0d", e.red, o_red_gain);
                        errors++;
                    end
                    if (o_green_gain !== e.green) begin
                        $error("green_gain exp %0d got %0d", e.green, o_green_gain);
                        errors++;
                    end
                    if (o_blue_gain !== e.blue) begin
                        $error("blue_gain exp %0d got %0d", e.blue, o_blue_gain);
                        errors++;
                    end
                    if (o_divide_error !== e.err) begin
                        $error("divide_error exp %0d got %0d", e.err, o_divide_error);
                        errors++;
                    end
                end
            end
            if (recv_hold > 0) begin
                i_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else if (long_hold_req && !long_hold_done) begin
                i_ready <= 1'b0;
                recv_hold <= LongHold;
                long_hold_done <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                recv_hold <= $urandom_range(0, 4);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic logic [awb_pkg::RatioW-1:0] pick_ratio(logic [awb_pkg::RatioW-1:0] typ);
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 3));
            3, 4: return 16'($urandom);
            default: return 16'($urandom_range(typ / 2, typ + typ / 2 + 1));
        endcase
    endfunction

    task automatic drain;
        while (pending_pairs.size() > 0 || i_valid || expected_gains.size() > 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_typical(logic [awb_pkg::RatioW-1:0] rg,
                                 logic [awb_pkg::RatioW-1:0] bg);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= awb_pkg::RegRgTyp;
        i_cfg_data <= rg;
        @(posedge i_clk);
        i_cfg_idx <= awb_pkg::RegBgTyp;
        i_cfg_data <= bg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rg_typ = rg;
        bg_typ = bg;
    endtask

    task automatic queue_random(int n);
        t_ratio_pair p;
        for (int k = 0; k < n; k++) begin
            p.rg = pick_ratio(rg_typ);
            p.bg = pick_ratio(bg_typ);
            pending_pairs.push_back(p);
        end
    endtask

    initial begin
        logic [awb_pkg::RatioW-1:0] typ_set[6][2];
        typ_set = '{'{16'd582, 16'd567}, '{16'hFFFF, 16'hFFFF}, '{16'd0, 16'd600},
                    '{16'd700, 16'd0}, '{16'd1, 16'hFFFF}, '{16'd0, 16'd0}};
        errors = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        rg_typ = 16'd582;
        bg_typ = 16'd567;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = awb_pkg::RegRgTyp;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_measured_rg = '0;
        i_measured_bg = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset typicals
        pending_pairs.push_back('{16'd0, 16'd567});
        pending_pairs.push_back('{16'd582, 16'd0});
        pending_pairs.push_back('{16'd0, 16'd0});
        pending_pairs.push_back('{16'd1, 16'd1});
        pending_pairs.push_back('{16'hFFFF, 16'hFFFF});
        pending_pairs.push_back('{16'd582, 16'd567});
        pending_pairs.push_back('{16'd300, 16'd300});
        pending_pairs.push_back('{16'd1000, 16'd700});
        pending_pairs.push_back('{16'd700, 16'd1000});
        pending_pairs.push_back('{16'd1, 16'hFFFF});
        pending_pairs.push_back('{16'hFFFF, 16'd1});
        pending_pairs.push_back('{16'hAAAA, 16'h5555});
        pending_pairs.push_back('{16'h5555, 16'hAAAA});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_typical(typ_set[ph][0], typ_set[ph][1]);
            if (ph == 1) long_hold_req = 1'b1;
            pending_pairs.push_back('{16'd0, 16'd1});
            pending_pairs.push_back('{16'hFFFF, 16'hFFFF});
            pending_pairs.push_back('{16'd1, 16'd1});
            queue_random(ph == 5 ? 150 : 190);
            drain();
        end
        write_typical(16'($urandom), 16'($urandom));
        quiet = 1'b1;
        queue_random(100);
        drain();

        if (errors == 0 && expected_gains.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- awb_channel_gain_balance.f -----
hw/rtl/awb_pkg.sv
hw/rtl/awb_div.sv
hw/rtl/awb_front.sv
hw/rtl/awb_fifo.sv
hw/rtl/awb_back.sv
hw/rtl/awb_channel_gain_balance.sv
dv/tb.sv
